// ----- src/tksd_pkg.sv -----
// Shared types, codes and decode helpers for the terminal key sequence decoder.
`timescale 1ns / 1ps
`default_nettype none

package tksd_pkg;

   localparam int PARAM_WIDTH = 16;

   localparam logic [PARAM_WIDTH-1:0] PARAM_MAX = {PARAM_WIDTH{1'b1}};

   // operation codes
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // byte values
   localparam logic [7:0] BYTE_ESC   = 8'h1b;
   localparam logic [7:0] BYTE_DEL   = 8'h7f;
   localparam logic [7:0] BYTE_BS    = 8'h08;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_CR    = 8'h0d;
   localparam logic [7:0] BYTE_LF    = 8'h0a;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_CTRL_OFS = 8'h60;
   localparam logic [7:0] BYTE_FINAL_LO = 8'h40;
   localparam logic [7:0] BYTE_FINAL_HI = 8'h7e;
   localparam logic [7:0] BYTE_LBRACKET = 8'h5b;
   localparam logic [7:0] BYTE_SS3_O    = 8'h4f;
   localparam logic [7:0] BYTE_SEMI     = 8'h3b;
   localparam logic [7:0] BYTE_TILDE    = 8'h7e;
   localparam logic [7:0] BYTE_Z        = 8'h5a;
   localparam logic [7:0] BYTE_DIGIT_0  = 8'h30;
   localparam logic [7:0] BYTE_DIGIT_9  = 8'h39;
   localparam logic [7:0] BYTE_P        = 8'h50;
   localparam logic [7:0] BYTE_S        = 8'h53;
   localparam logic [7:0] BYTE_A        = 8'h41;
   localparam logic [7:0] BYTE_B        = 8'h42;
   localparam logic [7:0] BYTE_C        = 8'h43;
   localparam logic [7:0] BYTE_D        = 8'h44;
   localparam logic [7:0] BYTE_F        = 8'h46;
   localparam logic [7:0] BYTE_H        = 8'h48;

   // key kinds
   localparam logic [4:0] KIND_NONE   = 5'd0;
   localparam logic [4:0] KIND_CHAR   = 5'd1;
   localparam logic [4:0] KIND_ENTER  = 5'd2;
   localparam logic [4:0] KIND_TAB    = 5'd3;
   localparam logic [4:0] KIND_BKSP   = 5'd4;
   localparam logic [4:0] KIND_ESC    = 5'd5;
   localparam logic [4:0] KIND_UP     = 5'd6;
   localparam logic [4:0] KIND_DOWN   = 5'd7;
   localparam logic [4:0] KIND_RIGHT  = 5'd8;
   localparam logic [4:0] KIND_LEFT   = 5'd9;
   localparam logic [4:0] KIND_HOME   = 5'd10;
   localparam logic [4:0] KIND_END    = 5'd11;
   localparam logic [4:0] KIND_INSERT = 5'd12;
   localparam logic [4:0] KIND_DELETE = 5'd13;
   localparam logic [4:0] KIND_PGUP   = 5'd14;
   localparam logic [4:0] KIND_PGDN   = 5'd15;
   localparam logic [4:0] KIND_F1     = 5'd16;
   localparam logic [4:0] KIND_F6     = 5'd21;
   localparam logic [4:0] KIND_F11    = 5'd26;

   // tilde numbers that open function key runs
   localparam logic [4:0] TILDE_F1  = 5'd11;
   localparam logic [4:0] TILDE_F6  = 5'd17;
   localparam logic [4:0] TILDE_F11 = 5'd23;

   typedef enum logic [1:0] {
      MODE_GROUND = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_CSI    = 2'd2,
      MODE_SS3    = 2'd3
   } mode_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [4:0] key_kind;
      logic [7:0] char_code;
      logic       shift_held;
      logic       alt_held;
      logic       ctrl_held;
   } rsp_type;

   // decoder to output stage
   typedef struct packed {
      logic    fire;
      rsp_type key;
   } step_type;

   function automatic rsp_type make_key(input logic [4:0] kind);
      rsp_type k;
      k = '0;
      k.key_kind = kind;
      return k;
   endfunction

   function automatic rsp_type plain_key(input logic [7:0] b);
      rsp_type k;
      k = make_key(KIND_CHAR);
      if (b == BYTE_CR || b == BYTE_LF) begin
         k = make_key(KIND_ENTER);
      end else if (b == BYTE_TAB) begin
         k = make_key(KIND_TAB);
      end else if (b == BYTE_DEL || b == BYTE_BS) begin
         k = make_key(KIND_BKSP);
      end else if (b < BYTE_SPACE) begin
         k.ctrl_held = 1'b1;
         k.char_code = b + BYTE_CTRL_OFS;
      end else begin
         k.char_code = b;
      end
      return k;
   endfunction

   function automatic logic [4:0] cursor_kind(input logic [7:0] b);
      logic [4:0] kind;
      case (b)
         BYTE_A:  kind = KIND_UP;
         BYTE_B:  kind = KIND_DOWN;
         BYTE_C:  kind = KIND_RIGHT;
         BYTE_D:  kind = KIND_LEFT;
         BYTE_H:  kind = KIND_HOME;
         BYTE_F:  kind = KIND_END;
         default: kind = KIND_NONE;
      endcase
      return kind;
   endfunction

   function automatic logic [4:0] tilde_kind(input logic [PARAM_WIDTH-1:0] n);
      logic [4:0] kind;
      logic [4:0] lo;
      lo   = n[4:0];
      kind = KIND_NONE;
      if (n == PARAM_WIDTH'(1) || n == PARAM_WIDTH'(7)) begin
         kind = KIND_HOME;
      end else if (n == PARAM_WIDTH'(2)) begin
         kind = KIND_INSERT;
      end else if (n == PARAM_WIDTH'(3)) begin
         kind = KIND_DELETE;
      end else if (n == PARAM_WIDTH'(4) || n == PARAM_WIDTH'(8)) begin
         kind = KIND_END;
      end else if (n == PARAM_WIDTH'(5)) begin
         kind = KIND_PGUP;
      end else if (n == PARAM_WIDTH'(6)) begin
         kind = KIND_PGDN;
      end else if (n >= PARAM_WIDTH'(11) && n <= PARAM_WIDTH'(15)) begin
         kind = KIND_F1 + (lo - TILDE_F1);
      end else if (n >= PARAM_WIDTH'(17) && n <= PARAM_WIDTH'(21)) begin
         kind = KIND_F6 + (lo - TILDE_F6);
      end else if (n == PARAM_WIDTH'(23) || n == PARAM_WIDTH'(24)) begin
         kind = KIND_F11 + (lo - TILDE_F11);
      end
      return kind;
   endfunction

   // v*10 + d, clamped to all ones
   function automatic logic [PARAM_WIDTH-1:0] push_digit(input logic [PARAM_WIDTH-1:0] v,
                                                         input logic [3:0] d);
      logic [PARAM_WIDTH+3:0] sum;
      sum = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {{PARAM_WIDTH{1'b0}}, d};
      if (sum[PARAM_WIDTH+3:PARAM_WIDTH] != 4'd0) begin
         return PARAM_MAX;
      end
      return sum[PARAM_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/terminal_key_sequence_decoder.sv -----
// A beat accepted into the input register is decoded combinationally, and its key, if any,
// is captured in the result register and shown on rsp_ once the result register is free.
// Throughput: one beat per cycle, set by the single decode stage between the input
// register and the result register; stall from rsp_ backs up into req_stall.
// Reset (synchronous, active high) empties both registers and returns the parser to
// ground with both parameters and the parameter index at zero.
`timescale 1ns / 1ps
`default_nettype none

module terminal_key_sequence_decoder
   import tksd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic     req_valid_ff;
   req_type  req_ff;
   logic     out_free;
   logic     advance;
   step_type step;

   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
   end

   tksd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_ff),
      .step    (step)
   );

   tksd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .step      (step),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_stall_from_full_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while result register can drain");

   a_held_beat_kept: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> req_valid_ff)
      else $error("undecoded beat lost from input register");

   a_result_from_decode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(req_valid_ff))
      else $error("result appeared without a decoded beat");

   a_flush_no_key_outside_esc: assert property (@(posedge clock) disable iff (reset)
      (advance && req_ff.operation == OP_FLUSH && step.fire) |->
         (step.key.key_kind == KIND_ESC))
      else $error("flush produced a key other than esc");
`endif

endmodule

`default_nettype wire

// ----- src/tksd_core.sv -----
// Parser state registers and combinational key decode.
`timescale 1ns / 1ps
`default_nettype none

module tksd_core
   import tksd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire req_type  item,
   output step_type      step
);

   mode_type               mode_ff, mode_in;
   logic                   index_ff, index_in;
   logic [PARAM_WIDTH-1:0] first_ff, first_in;
   logic [PARAM_WIDTH-1:0] second_ff, second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_GROUND;
         index_ff  <= 1'b0;
         first_ff  <= '0;
         second_ff <= '0;
      end else if (advance) begin
         mode_ff   <= mode_in;
         index_ff  <= index_in;
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   logic [7:0]             b;
   logic [4:0]             kind;
   logic [PARAM_WIDTH-1:0] modp;
   logic [2:0]             modm;
   logic                   clear;

   assign b    = item.data_byte;
   assign modp = index_ff ? second_ff : '0;
   assign modm = modp[2:0] - 3'd1;

   always_comb begin
      mode_in   = mode_ff;
      index_in  = index_ff;
      first_in  = first_ff;
      second_in = second_ff;
      clear     = 1'b0;
      step      = '0;
      kind      = KIND_NONE;
      if (item.operation == OP_FLUSH) begin
         clear     = 1'b1;
         step.fire = (mode_ff == MODE_ESC);
         step.key  = make_key(KIND_ESC);
      end else begin
         case (mode_ff)
            MODE_GROUND: begin
               if (b == BYTE_ESC) begin
                  mode_in = MODE_ESC;
               end else begin
                  step.fire = 1'b1;
                  step.key  = plain_key(b);
               end
            end
            MODE_ESC: begin
               if (b == BYTE_LBRACKET) begin
                  mode_in = MODE_CSI;
               end else if (b == BYTE_SS3_O) begin
                  mode_in = MODE_SS3;
               end else if (b == BYTE_ESC) begin
                  step.fire = 1'b1;
                  step.key  = make_key(KIND_ESC);
               end else begin
                  clear     = 1'b1;
                  mode_in   = MODE_GROUND;
                  step.fire = 1'b1;
                  step.key  = plain_key(b);
                  step.key.alt_held = 1'b1;
               end
            end
            MODE_CSI: begin
               if (b == BYTE_ESC) begin
                  clear   = 1'b1;
                  mode_in = MODE_ESC;
               end else if (b >= BYTE_DIGIT_0 && b <= BYTE_DIGIT_9) begin
                  if (index_ff) begin
                     second_in = push_digit(second_ff, b[3:0]);
                  end else begin
                     first_in = push_digit(first_ff, b[3:0]);
                  end
               end else if (b == BYTE_SEMI) begin
                  index_in = 1'b1;
               end else if (b >= BYTE_FINAL_LO && b <= BYTE_FINAL_HI) begin
                  clear = 1'b1;
                  if (b == BYTE_Z) begin
                     step.fire = 1'b1;
                     step.key  = make_key(KIND_TAB);
                     step.key.shift_held = 1'b1;
                  end else begin
                     kind = (b == BYTE_TILDE) ? tilde_kind(first_ff) : cursor_kind(b);
                     step.fire = (kind != KIND_NONE);
                     step.key  = make_key(kind);
                     // modifier code m >= 2 carries (m-1) as shift/alt/ctrl bits
                     if (modp >= PARAM_WIDTH'(2)) begin
                        step.key.shift_held = modm[0];
                        step.key.alt_held   = modm[1];
                        step.key.ctrl_held  = modm[2];
                     end
                  end
               end
            end
            MODE_SS3: begin
               clear = 1'b1;
               if (b == BYTE_ESC) begin
                  mode_in = MODE_ESC;
               end else if (b >= BYTE_P && b <= BYTE_S) begin
                  step.fire = 1'b1;
                  step.key  = make_key(KIND_F1 + {3'd0, b[1:0]});
               end else begin
                  kind      = cursor_kind(b);
                  step.fire = (kind != KIND_NONE);
                  step.key  = make_key(kind);
               end
            end
            default: begin
               clear = 1'b1;
            end
         endcase
         if (clear && mode_in != MODE_ESC) begin
            mode_in = MODE_GROUND;
         end
      end
      if (clear) begin
         if (item.operation == OP_FLUSH) begin
            mode_in = MODE_GROUND;
         end
         index_in  = 1'b0;
         first_in  = '0;
         second_in = '0;
      end
   end

endmodule

`default_nettype wire

// ----- src/tksd_out_reg.sv -----
// Result register with stall handling.
`timescale 1ns / 1ps
`default_nettype none

module tksd_out_reg
   import tksd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire step_type step,
   output logic          free,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   assign free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance && step.fire) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step.fire) begin
         data_ff <= step.key;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the terminal key sequence decoder: directed and random byte streams.
`timescale 1ns / 1ps

module tb;
   import tksd_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int ITEM_TARGET   = 1900;
   localparam int REPORT_LIMIT  = 10;
   localparam int DRAIN_CYCLES  = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // decoder copy
   mode_type               dec_mode = MODE_GROUND;
   logic                   dec_second = 1'b0;
   logic [PARAM_WIDTH-1:0] dec_p1 = '0;
   logic [PARAM_WIDTH-1:0] dec_p2 = '0;

   rsp_type key_queue[$];
   int      items_sent = 0;
   int      failures = 0;
   int      cycles = 0;
   bit      send_quiet = 1'b0;
   bit      recv_quiet = 1'b0;
   int      hold_left = 0;
   int      stall_left = 0;

   terminal_key_sequence_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- key prediction

   function automatic rsp_type key_of(input logic [4:0] kind);
      rsp_type k;
      k = '0;
      k.key_kind = kind;
      return k;
   endfunction

   function automatic rsp_type plain_byte_key(input logic [7:0] b);
      rsp_type k;
      k = key_of(KIND_CHAR);
      case (b)
         BYTE_CR, BYTE_LF:  k = key_of(KIND_ENTER);
         BYTE_TAB:          k = key_of(KIND_TAB);
         BYTE_DEL, BYTE_BS: k = key_of(KIND_BKSP);
         default: begin
            if (b < BYTE_SPACE) begin
               k.ctrl_held = 1'b1;
               k.char_code = b + BYTE_CTRL_OFS;
            end else begin
               k.char_code = b;
            end
         end
      endcase
      return k;
   endfunction

   function automatic logic [4:0] arrow_kind(input logic [7:0] b);
      case (b)
         BYTE_A:  return KIND_UP;
         BYTE_B:  return KIND_DOWN;
         BYTE_C:  return KIND_RIGHT;
         BYTE_D:  return KIND_LEFT;
         BYTE_H:  return KIND_HOME;
         BYTE_F:  return KIND_END;
         default: return KIND_NONE;
      endcase
   endfunction

   function automatic logic [4:0] tilde_key_kind(input int unsigned n);
      if (n == 1 || n == 7) return KIND_HOME;
      if (n == 2) return KIND_INSERT;
      if (n == 3) return KIND_DELETE;
      if (n == 4 || n == 8) return KIND_END;
      if (n == 5) return KIND_PGUP;
      if (n == 6) return KIND_PGDN;
      if (n >= TILDE_F1 && n < TILDE_F1 + 5) return KIND_F1 + 5'(n - TILDE_F1);
      if (n >= TILDE_F6 && n < TILDE_F6 + 5) return KIND_F6 + 5'(n - TILDE_F6);
      if (n >= TILDE_F11 && n < TILDE_F11 + 2) return KIND_F11 + 5'(n - TILDE_F11);
      return KIND_NONE;
   endfunction

   // modifier m encodes (m-1): bit0 shift, bit1 alt, bit2 ctrl
   function automatic rsp_type with_modifier(input rsp_type k,
                                             input logic [PARAM_WIDTH-1:0] m);
      logic [PARAM_WIDTH-1:0] mm;
      if (m >= 2) begin
         mm = m - 1'b1;
         k.shift_held = mm[0];
         k.alt_held   = mm[1];
         k.ctrl_held  = mm[2];
      end
      return k;
   endfunction

   function automatic logic [PARAM_WIDTH-1:0] next_param(input logic [PARAM_WIDTH-1:0] v,
                                                        input logic [7:0] b);
      longint unsigned acc;
      acc = longint'(v) * 10 + longint'(b - BYTE_DIGIT_0);
      if (acc > PARAM_MAX) return PARAM_MAX;
      return acc[PARAM_WIDTH-1:0];
   endfunction

   function automatic bit close_csi(input logic [7:0] b, output rsp_type k);
      logic [PARAM_WIDTH-1:0] m;
      logic [4:0]             kind;
      m = dec_second ? dec_p2 : '0;
      k = key_of(KIND_NONE);
      if (b == BYTE_TILDE) begin
         kind = tilde_key_kind(dec_p1);
      end else if (b == BYTE_Z) begin
         k = key_of(KIND_TAB);
         k.shift_held = 1'b1;
         return 1'b1;
      end else begin
         kind = arrow_kind(b);
      end
      if (kind == KIND_NONE) return 1'b0;
      k = with_modifier(key_of(kind), m);
      return 1'b1;
   endfunction

   task automatic clear_decoder();
      dec_mode   = MODE_GROUND;
      dec_second = 1'b0;
      dec_p1     = '0;
      dec_p2     = '0;
   endtask

   task automatic decode_beat(input req_type r, output bit got, output rsp_type k);
      logic [7:0] b;
      logic [4:0] kind;
      b   = r.data_byte;
      got = 1'b0;
      k   = key_of(KIND_NONE);
      if (r.operation == OP_FLUSH) begin
         got = (dec_mode == MODE_ESC);
         if (got) k = key_of(KIND_ESC);
         clear_decoder();
      end else begin
         case (dec_mode)
            MODE_GROUND: begin
               if (b == BYTE_ESC) begin
                  dec_mode = MODE_ESC;
               end else begin
                  k   = plain_byte_key(b);
                  got = 1'b1;
               end
            end
            MODE_ESC: begin
               if (b == BYTE_LBRACKET) begin
                  dec_mode = MODE_CSI;
               end else if (b == BYTE_SS3_O) begin
                  dec_mode = MODE_SS3;
               end else if (b == BYTE_ESC) begin
                  k   = key_of(KIND_ESC);
                  got = 1'b1;
               end else begin
                  clear_decoder();
                  k = plain_byte_key(b);
                  k.alt_held = 1'b1;
                  got = 1'b1;
               end
            end
            MODE_CSI: begin
               if (b == BYTE_ESC) begin
                  clear_decoder();
                  dec_mode = MODE_ESC;
               end else if (b >= BYTE_DIGIT_0 && b <= BYTE_DIGIT_9) begin
                  if (dec_second) dec_p2 = next_param(dec_p2, b);
                  else dec_p1 = next_param(dec_p1, b);
               end else if (b == BYTE_SEMI) begin
                  dec_second = 1'b1;
               end else if (b >= BYTE_FINAL_LO && b <= BYTE_FINAL_HI) begin
                  got = close_csi(b, k);
                  clear_decoder();
               end
            end
            default: begin
               clear_decoder();
               if (b == BYTE_ESC) begin
                  dec_mode = MODE_ESC;
               end else if (b >= BYTE_P && b <= BYTE_S) begin
                  k   = key_of(KIND_F1 + 5'(b - BYTE_P));
                  got = 1'b1;
               end else begin
                  kind = arrow_kind(b);
                  if (kind != KIND_NONE) begin
                     k   = key_of(kind);
                     got = 1'b1;
                  end
               end
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------- handshakes

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!recv_quiet && $urandom_range(0, 99) < 30) stall_left = idle_gap() + 1;
      end
   end

   // values seen at the falling edge hold through the next rising edge
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (key_queue.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected key: kind=%0d code=%02h shift=%0b alt=%0b ctrl=%0b",
                        rsp_data.key_kind, rsp_data.char_code, rsp_data.shift_held,
                        rsp_data.alt_held, rsp_data.ctrl_held);
         end else begin
            want = key_queue.pop_front();
            if (want.key_kind != rsp_data.key_kind || want.char_code != rsp_data.char_code ||
                want.shift_held != rsp_data.shift_held || want.alt_held != rsp_data.alt_held ||
                want.ctrl_held != rsp_data.ctrl_held) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("key mismatch: expected kind=%0d code=%02h s/a/c=%0b%0b%0b,",
                           want.key_kind, want.char_code, want.shift_held, want.alt_held,
                           want.ctrl_held,
                           " got kind=%0d code=%02h s/a/c=%0b%0b%0b",
                           rsp_data.key_kind, rsp_data.char_code,
                           rsp_data.shift_held, rsp_data.alt_held, rsp_data.ctrl_held);
            end
         end
      end
   end

   // called at a rising edge; returns at the edge that takes the beat
   task automatic send_beat(input logic op, input logic [7:0] b);
      req_type item;
      int      gap;
      bit      taken;
      bit      got;
      rsp_type k;
      item.operation = op;
      item.data_byte = b;
      gap = send_quiet ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      decode_beat(item, got, k);
      if (got) key_queue.push_back(k);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_beat(OP_BYTE, b);
   endtask

   task automatic send_number(input int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // ---------------------------------------------------------------- stimulus pieces

   function automatic logic [7:0] cursor_byte();
      case ($urandom_range(0, 5))
         0:       return BYTE_A;
         1:       return BYTE_B;
         2:       return BYTE_C;
         3:       return BYTE_D;
         4:       return BYTE_H;
         default: return BYTE_F;
      endcase
   endfunction

   // bytes that CSI neither collects nor treats as a final
   function automatic logic [7:0] stray_byte();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(8'h00, 8'h1a));
         1:       return 8'($urandom_range(8'h1c, 8'h2f));
         2:       return 8'($urandom_range(8'h3c, 8'h3f));
         default: return 8'($urandom_range(8'h7f, 8'hff));
      endcase
   endfunction

   function automatic int unsigned param_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 24);
      if (r < 85) return $urandom_range(0, 99);
      if (r < 95) return $urandom_range(100, 9999);
      return $urandom_range(65530, 9999999);
   endfunction

   task automatic send_csi();
      int r;
      send_byte(BYTE_ESC);
      send_byte(BYTE_LBRACKET);
      if ($urandom_range(0, 9) < 8) send_number(param_value());
      if ($urandom_range(0, 9) == 0) send_byte(stray_byte());
      if ($urandom_range(0, 2) != 0) begin
         send_byte(BYTE_SEMI);
         if ($urandom_range(0, 5) == 0) send_byte(BYTE_SEMI);
         if ($urandom_range(0, 5) != 0) begin
            if ($urandom_range(0, 4) != 0) send_number($urandom_range(1, 9));
            else send_number(param_value());
         end
         if ($urandom_range(0, 9) == 0) begin
            send_byte(BYTE_SEMI);
            send_number($urandom_range(0, 99));
         end
      end
      r = $urandom_range(0, 19);
      if (r < 8) send_byte(BYTE_TILDE);
      else if (r < 10) send_byte(BYTE_Z);
      else if (r < 16) send_byte(cursor_byte());
      else send_byte(8'($urandom_range(BYTE_FINAL_LO, BYTE_FINAL_HI)));
   endtask

   task automatic send_ss3();
      int r;
      send_byte(BYTE_ESC);
      send_byte(BYTE_SS3_O);
      r = $urandom_range(0, 19);
      if (r < 10) send_byte(8'($urandom_range(BYTE_P, BYTE_S)));
      else if (r < 16) send_byte(cursor_byte());
      else if (r < 19) send_byte(8'($urandom_range(0, 255)));
      else send_byte(BYTE_ESC);
   endtask

   task automatic send_random_sequence();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) begin
         send_byte(8'($urandom_range(0, 255)));
      end else if (r < 55) begin
         send_csi();
      end else if (r < 67) begin
         send_ss3();
      end else if (r < 80) begin
         send_byte(BYTE_ESC);
         send_byte(8'($urandom_range(0, 255)));
      end else if (r < 86) begin
         send_byte(BYTE_ESC);
         send_beat(OP_FLUSH, 8'($urandom_range(0, 255)));
      end else if (r < 93) begin
         // sequence cut short by a timeout or a fresh escape
         send_byte(BYTE_ESC);
         send_byte($urandom_range(0, 1) ? BYTE_LBRACKET : BYTE_SS3_O);
         if ($urandom_range(0, 1)) send_number(param_value());
         if ($urandom_range(0, 1)) send_beat(OP_FLUSH, 8'($urandom_range(0, 255)));
         else send_byte(BYTE_ESC);
      end else begin
         send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(BYTE_CR);
      send_byte(BYTE_TAB);
      send_byte(BYTE_DEL);
      send_byte(BYTE_ESC);
      send_byte(BYTE_ESC);              // esc key, parser stays in escape
      send_beat(OP_FLUSH, 8'hff);       // esc key from the timeout
      send_byte(BYTE_ESC);
      send_byte(8'h61);                 // alt-a
      send_byte(BYTE_ESC);
      send_byte(BYTE_LBRACKET);
      send_number(99999);               // saturates
      send_byte(BYTE_SEMI);
      send_number(8);                   // shift+alt+ctrl
      send_byte(BYTE_A);
      send_byte(BYTE_ESC);
      send_byte(BYTE_SS3_O);
      send_byte(BYTE_P);
      send_byte(BYTE_ESC);
      send_byte(BYTE_LBRACKET);
      send_byte(BYTE_Z);
      send_beat(OP_FLUSH, 8'h00);       // nothing pending
   endtask

   task automatic test_random_traffic(input int target);
      while (items_sent < target) send_random_sequence();
   endtask

   task automatic test_backpressure();
      send_quiet = 1'b1;
      hold_left  = 200;
      for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(BYTE_SPACE, 8'h7e)));
      send_quiet = 1'b0;
   endtask

   task automatic test_steady_stream();
      int start;
      start = items_sent;
      send_quiet = 1'b1;
      recv_quiet = 1'b1;
      while (items_sent < start + 150) send_random_sequence();
      send_quiet = 1'b0;
      recv_quiet = 1'b0;
   endtask

   task automatic finish_run();
      req_valid <= 1'b0;
      while (key_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(900);
      test_backpressure();
      test_steady_stream();
      test_random_traffic(ITEM_TARGET);
      finish_run();
   end

endmodule

// ----- files.f -----
src/tksd_pkg.sv
src/tksd_core.sv
src/tksd_out_reg.sv
src/terminal_key_sequence_decoder.sv
dv/tb.sv
